// ----- rtl/core/apjq_pkg.sv -----
// Shared types, codes and default constants of the aging priority job queue.
package apjq_pkg;

    // Fixed field widths of the item ports
    localparam int TAG_PORT_W  = 8;
    localparam int PRIO_W      = 8;
    localparam int COUNT_OUT_W = 5;
    localparam int STATUS_W    = 2;

    // Defaults for the top-level parameters
    localparam int QUEUE_DEPTH_DEF  = 16;
    localparam int PRIORITY_MAX_DEF = 6;
    localparam int TAG_WIDTH_DEF    = 8;

    // Event kinds
    typedef enum logic [1:0] {
        FUNC_SUBMIT = 2'd0,
        FUNC_DONE   = 2'd1,
        FUNC_CANCEL = 2'd2
    } func_t;

    // Result status codes
    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK        = 2'd0,
        STATUS_FULL      = 2'd1,
        STATUS_IDLE_DONE = 2'd2
    } status_t;

    // Decision of the entry unit for one queue entry
    typedef struct packed {
        logic wr_en;  // write the produced entry back to the queue
        logic take;   // submit: insertion point found; cancel: entry kept
    } apjq_ctl_t;

endpackage

// ----- rtl/core/apjq_ram.sv -----
// Queue storage: one write port, one registered read port.
module apjq_ram
    import apjq_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF,
    parameter int WIDTH = TAG_WIDTH_DEF + PRIO_W,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
)
(
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write one entry
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Register the read data
    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/core/apjq_unit.sv -----
// Shared entry unit: priority compare, tag match and aging for one queue entry.
module apjq_unit
    import apjq_pkg::*;
#(
    parameter int TW = TAG_WIDTH_DEF
)
(
    input  logic              cancel_mode,
    input  logic              tail,
    input  logic              entry_vld,
    input  logic              ins,
    input  logic [TW-1:0]     key_tag,
    input  logic [PRIO_W-1:0] new_prio,
    input  logic [TW-1:0]     rd_tag,
    input  logic [PRIO_W-1:0] rd_prio,
    input  logic [TW-1:0]     carry_tag,
    input  logic [PRIO_W-1:0] carry_prio,
    output apjq_ctl_t         ctl,
    output logic [TW-1:0]     wr_tag,
    output logic [PRIO_W-1:0] wr_prio
);

    logic              hit;
    logic              keep;
    logic [PRIO_W-1:0] aged_prio;

    // Compare new job against the entry; age the displaced entry, saturating
    assign hit       = (new_prio != '0) && (new_prio > rd_prio);
    assign keep      = (rd_tag != key_tag);
    assign aged_prio = (carry_prio == '1) ? carry_prio : carry_prio + PRIO_W'(1);

    always_comb
    begin
        if (cancel_mode)
        begin
            // Compact: keep every entry with another tag
            ctl.wr_en = entry_vld && keep;
            ctl.take  = entry_vld && keep;
            wr_tag    = rd_tag;
            wr_prio   = rd_prio;
        end
        else
        begin
            // Insert: new job at the hit point, then ripple the carry forward
            ctl.wr_en = (entry_vld && (ins || hit)) || tail;
            ctl.take  = entry_vld && hit && !ins;
            wr_tag    = ins ? carry_tag : key_tag;
            wr_prio   = ins ? aged_prio : new_prio;
        end
    end

endmodule

// ----- rtl/core/aging_priority_job_queue.sv -----
// Sequence: a submit or cancel makes one pass over the waiting jobs (ST_PASS); a done or
// unused event, or a submit on a full queue, skips the pass. Each item then goes through
// ST_HEAD, ST_POP when a job starts, and ST_OUT, where a held result stalls it.
// Flow: one item at a time; a submit or cancel is bound by its pass over the queue memory,
// and the next item is accepted only once the result has gone to the output register.
// Reset: asynchronous, clears count, head, engine state and handshakes; memory is not cleared.
module aging_priority_job_queue
    import apjq_pkg::*;
#(
    parameter int QUEUE_DEPTH  = QUEUE_DEPTH_DEF,
    parameter int PRIORITY_MAX = PRIORITY_MAX_DEF,
    parameter int TAG_WIDTH    = TAG_WIDTH_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [1:0]             func,
    input  logic [TAG_PORT_W-1:0]  ctx_tag,
    input  logic [PRIO_W-1:0]      req_priority,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic                   started,
    output logic [TAG_PORT_W-1:0]  started_tag,
    output logic [PRIO_W-1:0]      started_priority,
    output logic [COUNT_OUT_W-1:0] queue_count,
    output logic [STATUS_W-1:0]    status
);

    localparam int TW = (TAG_WIDTH < TAG_PORT_W) ? TAG_WIDTH : TAG_PORT_W;
    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int EW = TW + PRIO_W;
    localparam logic [CW-1:0]     DEPTH_C = CW'(QUEUE_DEPTH);
    localparam logic [PRIO_W-1:0] PMAX_C  = PRIO_W'(PRIORITY_MAX);

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_PASS = 5'b00010,
        ST_HEAD = 5'b00100,
        ST_POP  = 5'b01000,
        ST_OUT  = 5'b10000
    } state_t;

    // Map a position in the queue to a memory address
    function automatic logic [AW-1:0] phys(input logic [AW-1:0] head,
                                           input logic [CW-1:0] idx);
        logic [CW:0] sum;
        begin
            sum = (CW+1)'(head) + (CW+1)'(idx);
            if (sum >= (CW+1)'(QUEUE_DEPTH))
            begin
                sum = sum - (CW+1)'(QUEUE_DEPTH);
            end
            phys = sum[AW-1:0];
        end
    endfunction

    // Control registers
    state_t              state_reg,     state_next;
    logic                cancel_reg,    cancel_next;
    logic [AW-1:0]       head_reg,      head_next;
    logic [CW-1:0]       count_reg,     count_next;
    logic                busy_reg,      busy_next;
    logic [CW-1:0]       rd_idx_reg,    rd_idx_next;
    logic                chk_vld_reg,   chk_vld_next;
    logic [CW-1:0]       chk_idx_reg,   chk_idx_next;
    logic [CW-1:0]       wr_idx_reg,    wr_idx_next;
    logic                ins_reg,       ins_next;
    logic                out_valid_reg, out_valid_next;

    // Payload registers
    logic [TW-1:0]       run_tag_reg,   run_tag_next;
    logic [TW-1:0]       key_tag_reg,   key_tag_next;
    logic [PRIO_W-1:0]   new_prio_reg,  new_prio_next;
    logic [TW-1:0]       carry_tag_reg, carry_tag_next;
    logic [PRIO_W-1:0]   carry_prio_reg, carry_prio_next;
    logic                res_started_reg, res_started_next;
    logic [TW-1:0]       res_tag_reg,   res_tag_next;
    logic [PRIO_W-1:0]   res_prio_reg,  res_prio_next;
    status_t             res_status_reg, res_status_next;
    logic                o_started_reg, o_started_next;
    logic [TAG_PORT_W-1:0] o_tag_reg,   o_tag_next;
    logic [PRIO_W-1:0]   o_prio_reg,    o_prio_next;
    logic [COUNT_OUT_W-1:0] o_count_reg, o_count_next;
    logic [STATUS_W-1:0] o_status_reg,  o_status_next;

    // Memory and entry unit connections
    logic                mem_we;
    logic [AW-1:0]       mem_waddr;
    logic [EW-1:0]       mem_wdata;
    logic [AW-1:0]       mem_raddr;
    logic [EW-1:0]       mem_rdata;
    logic [TW-1:0]       rd_tag;
    logic [PRIO_W-1:0]   rd_prio;
    logic                pass_tail;
    logic                rd_go;
    apjq_ctl_t           ctl;
    logic [TW-1:0]       wr_tag;
    logic [PRIO_W-1:0]   wr_prio;
    logic [TW-1:0]       in_tag;
    logic [PRIO_W-1:0]   in_prio;

    assign rd_tag  = mem_rdata[EW-1:PRIO_W];
    assign rd_prio = mem_rdata[PRIO_W-1:0];
    assign in_tag  = ctx_tag[TW-1:0];
    assign in_prio = (req_priority > PMAX_C) ? PMAX_C : req_priority;

    assign in_ready  = (state_reg == ST_IDLE);
    assign rd_go     = (state_reg == ST_PASS) && (rd_idx_reg < count_reg);
    assign pass_tail = (state_reg == ST_PASS) && !chk_vld_reg && (rd_idx_reg == count_reg);

    apjq_ram #(
        .DEPTH (QUEUE_DEPTH),
        .WIDTH (EW)
    ) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    apjq_unit #(
        .TW (TW)
    ) u_unit (
        .cancel_mode (cancel_reg),
        .tail        (pass_tail && !cancel_reg),
        .entry_vld   ((state_reg == ST_PASS) && chk_vld_reg),
        .ins         (ins_reg),
        .key_tag     (key_tag_reg),
        .new_prio    (new_prio_reg),
        .rd_tag      (rd_tag),
        .rd_prio     (rd_prio),
        .carry_tag   (carry_tag_reg),
        .carry_prio  (carry_prio_reg),
        .ctl         (ctl),
        .wr_tag      (wr_tag),
        .wr_prio     (wr_prio)
    );

    // Memory addressing: head read for a start, otherwise the pass pointers
    always_comb
    begin
        mem_raddr = (state_reg == ST_HEAD) ? head_reg : phys(head_reg, rd_idx_reg);
        mem_we    = ctl.wr_en;
        mem_wdata = {wr_tag, wr_prio};
        if (cancel_reg)
        begin
            mem_waddr = phys(head_reg, wr_idx_reg);
        end
        else if (pass_tail)
        begin
            mem_waddr = phys(head_reg, count_reg);
        end
        else
        begin
            mem_waddr = phys(head_reg, chk_idx_reg);
        end
    end

    // Sequencer
    always_comb
    begin
        state_next       = state_reg;
        cancel_next      = cancel_reg;
        head_next        = head_reg;
        count_next       = count_reg;
        busy_next        = busy_reg;
        rd_idx_next      = rd_idx_reg;
        chk_vld_next     = chk_vld_reg;
        chk_idx_next     = chk_idx_reg;
        wr_idx_next      = wr_idx_reg;
        ins_next         = ins_reg;
        run_tag_next     = run_tag_reg;
        key_tag_next     = key_tag_reg;
        new_prio_next    = new_prio_reg;
        carry_tag_next   = carry_tag_reg;
        carry_prio_next  = carry_prio_reg;
        res_started_next = res_started_reg;
        res_tag_next     = res_tag_reg;
        res_prio_next    = res_prio_reg;
        res_status_next  = res_status_reg;
        out_valid_next   = out_valid_reg && !out_ready;
        o_started_next   = o_started_reg;
        o_tag_next       = o_tag_reg;
        o_prio_next      = o_prio_reg;
        o_count_next     = o_count_reg;
        o_status_next    = o_status_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    // Decode the event
                    res_started_next = 1'b0;
                    res_tag_next     = '0;
                    res_prio_next    = '0;
                    res_status_next  = STATUS_OK;
                    key_tag_next     = in_tag;
                    new_prio_next    = in_prio;
                    rd_idx_next      = '0;
                    chk_vld_next     = 1'b0;
                    wr_idx_next      = '0;
                    ins_next         = 1'b0;
                    state_next       = ST_HEAD;
                    case (func_t'(func))
                        FUNC_SUBMIT:
                        begin
                            if (count_reg == DEPTH_C)
                            begin
                                res_status_next = STATUS_FULL;
                            end
                            else
                            begin
                                cancel_next = 1'b0;
                                state_next  = ST_PASS;
                            end
                        end
                        FUNC_DONE:
                        begin
                            if (busy_reg)
                            begin
                                busy_next = 1'b0;
                            end
                            else
                            begin
                                res_status_next = STATUS_IDLE_DONE;
                            end
                        end
                        FUNC_CANCEL:
                        begin
                            cancel_next = 1'b1;
                            state_next  = ST_PASS;
                            if (busy_reg && (run_tag_reg == in_tag))
                            begin
                                busy_next = 1'b0;
                            end
                        end
                        default:
                        begin
                            state_next = ST_HEAD;
                        end
                    endcase
                end
            end

            ST_PASS:
            begin
                // Issue the next read
                chk_vld_next = rd_go;
                chk_idx_next = rd_idx_reg;
                if (rd_go)
                begin
                    rd_idx_next = rd_idx_reg + CW'(1);
                end
                // Act on the entry read last cycle
                if (chk_vld_reg)
                begin
                    carry_tag_next  = rd_tag;
                    carry_prio_next = rd_prio;
                    if (ctl.take)
                    begin
                        if (cancel_reg)
                        begin
                            wr_idx_next = wr_idx_reg + CW'(1);
                        end
                        else
                        begin
                            ins_next = 1'b1;
                        end
                    end
                end
                // Close the pass
                if (pass_tail)
                begin
                    count_next = cancel_reg ? wr_idx_reg : count_reg + CW'(1);
                    state_next = ST_HEAD;
                end
            end

            ST_HEAD:
            begin
                state_next = (!busy_reg && (count_reg != '0)) ? ST_POP : ST_OUT;
            end

            ST_POP:
            begin
                // Start the head job
                res_started_next = 1'b1;
                res_tag_next     = rd_tag;
                res_prio_next    = rd_prio;
                busy_next        = 1'b1;
                run_tag_next     = rd_tag;
                count_next       = count_reg - CW'(1);
                head_next        = (head_reg == AW'(QUEUE_DEPTH - 1)) ? '0
                                                                     : head_reg + AW'(1);
                state_next       = ST_OUT;
            end

            ST_OUT:
            begin
                // Hand the result to the output register once it is free
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    o_started_next = res_started_reg;
                    o_tag_next     = TAG_PORT_W'(res_tag_reg);
                    o_prio_next    = res_prio_reg;
                    o_count_next   = COUNT_OUT_W'(count_reg);
                    o_status_next  = res_status_reg;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cancel_reg    <= 1'b0;
            head_reg      <= '0;
            count_reg     <= '0;
            busy_reg      <= 1'b0;
            rd_idx_reg    <= '0;
            chk_vld_reg   <= 1'b0;
            chk_idx_reg   <= '0;
            wr_idx_reg    <= '0;
            ins_reg       <= 1'b0;
            run_tag_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cancel_reg    <= cancel_next;
            head_reg      <= head_next;
            count_reg     <= count_next;
            busy_reg      <= busy_next;
            rd_idx_reg    <= rd_idx_next;
            chk_vld_reg   <= chk_vld_next;
            chk_idx_reg   <= chk_idx_next;
            wr_idx_reg    <= wr_idx_next;
            ins_reg       <= ins_next;
            run_tag_reg   <= run_tag_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        key_tag_reg     <= key_tag_next;
        new_prio_reg    <= new_prio_next;
        carry_tag_reg   <= carry_tag_next;
        carry_prio_reg  <= carry_prio_next;
        res_started_reg <= res_started_next;
        res_tag_reg     <= res_tag_next;
        res_prio_reg    <= res_prio_next;
        res_status_reg  <= res_status_next;
        o_started_reg   <= o_started_next;
        o_tag_reg       <= o_tag_next;
        o_prio_reg      <= o_prio_next;
        o_count_reg     <= o_count_next;
        o_status_reg    <= o_status_next;
    end

    assign out_valid        = out_valid_reg;
    assign started          = o_started_reg;
    assign started_tag      = o_tag_reg;
    assign started_priority = o_prio_reg;
    assign queue_count      = o_count_reg;
    assign status           = o_status_reg;

`ifndef ASSERT_OFF
    // Queue never holds more jobs than it has room for
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= DEPTH_C)
        else $error("queue count above depth");

    // A job starts only on an idle engine with a waiting job
    a_pop_legal: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_POP) |-> (!busy_reg && (count_reg != '0)))
        else $error("start without idle engine or waiting job");

    // An insert pass never runs on a full queue
    a_insert_room: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_PASS) && !cancel_reg) |-> (count_reg < DEPTH_C))
        else $error("insert pass on full queue");

    // A start leaves the engine busy
    a_pop_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_POP) |=> busy_reg)
        else $error("engine not busy after start");
`endif

endmodule

// ----- test/tb.sv -----
// Self-checking testbench for the aging priority job queue scheduler.
`timescale 1ns / 1ps

module tb;
    import apjq_pkg::*;

    // Event kind 3 has no meaning in the block and must be ignored
    localparam logic [1:0] FUNC_UNUSED = 2'd3;

    // Expected result of one scheduling event
    typedef struct {
        logic                   started;
        logic [TAG_PORT_W-1:0]  tag;
        logic [PRIO_W-1:0]      prio;
        logic [COUNT_OUT_W-1:0] count;
        status_t                status;
    } sched_outcome_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   in_valid = 1'b0;
    logic                   in_ready;
    logic [1:0]             func = '0;
    logic [TAG_PORT_W-1:0]  ctx_tag = '0;
    logic [PRIO_W-1:0]      req_priority = '0;
    logic                   out_valid;
    logic                   out_ready = 1'b0;
    logic                   started;
    logic [TAG_PORT_W-1:0]  started_tag;
    logic [PRIO_W-1:0]      started_priority;
    logic [COUNT_OUT_W-1:0] queue_count;
    logic [STATUS_W-1:0]    status;

    // Scheduler state as predicted
    logic [TAG_PORT_W-1:0]  job_tag [QUEUE_DEPTH_DEF];
    logic [PRIO_W-1:0]      job_prio [QUEUE_DEPTH_DEF];
    int                     jobs_waiting = 0;
    bit                     engine_on = 1'b0;
    logic [TAG_PORT_W-1:0]  engine_tag = '0;

    sched_outcome_t         outcome_q [$];

    bit sender_gaps_on = 1'b1;
    bit receiver_stalls_on = 1'b1;
    int hold_request = 0;
    int mismatches = 0;
    int results_seen = 0;
    int n_submit = 0;
    int n_dropped = 0;
    int n_done = 0;
    int n_idle_done = 0;
    int n_cancel = 0;
    int n_unused = 0;
    int n_started = 0;
    int deepest = 0;

    aging_priority_job_queue #(
        .QUEUE_DEPTH  (QUEUE_DEPTH_DEF),
        .PRIORITY_MAX (PRIORITY_MAX_DEF),
        .TAG_WIDTH    (TAG_WIDTH_DEF)
    ) i_dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .func             (func),
        .ctx_tag          (ctx_tag),
        .req_priority     (req_priority),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .started          (started),
        .started_tag      (started_tag),
        .started_priority (started_priority),
        .queue_count      (queue_count),
        .status           (status)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Apply one event to the predicted scheduler and return its result
    function automatic sched_outcome_t schedule_event(logic [1:0] f, logic [7:0] tag,
                                                      logic [7:0] req);
        sched_outcome_t o;
        logic [PRIO_W-1:0] pr;
        int pos;
        int w;
        bit found;
        o.started = 1'b0;
        o.tag = '0;
        o.prio = '0;
        o.status = STATUS_OK;
        case (f)
            FUNC_SUBMIT:
            begin
                if (jobs_waiting >= QUEUE_DEPTH_DEF)
                    o.status = STATUS_FULL;
                else
                begin
                    pr = (req > PRIORITY_MAX_DEF) ? PRIO_W'(PRIORITY_MAX_DEF) : req;
                    pos = jobs_waiting;
                    found = 1'b0;
                    // place ahead of the first entry of lower priority
                    if (pr != 0 && jobs_waiting != 0)
                        for (int i = 0; i < jobs_waiting; i++)
                            if (!found && pr > job_prio[i])
                            begin
                                pos = i;
                                found = 1'b1;
                            end
                    // shift the entries behind and age them, saturating
                    for (int i = jobs_waiting; i > pos; i--)
                    begin
                        job_tag[i] = job_tag[i-1];
                        job_prio[i] = (job_prio[i-1] == 8'hFF) ? 8'hFF : job_prio[i-1] + 8'd1;
                    end
                    job_tag[pos] = tag;
                    job_prio[pos] = pr;
                    jobs_waiting++;
                end
            end
            FUNC_DONE:
            begin
                if (engine_on)
                    engine_on = 1'b0;
                else
                    o.status = STATUS_IDLE_DONE;
            end
            FUNC_CANCEL:
            begin
                // drop every waiting job with the tag, keep order
                w = 0;
                for (int r = 0; r < jobs_waiting; r++)
                    if (job_tag[r] != tag)
                    begin
                        job_tag[w] = job_tag[r];
                        job_prio[w] = job_prio[r];
                        w++;
                    end
                jobs_waiting = w;
                if (engine_on && engine_tag == tag)
                    engine_on = 1'b0;
            end
            default:
            begin
            end
        endcase
        // start the head job on an idle engine
        if (!engine_on && jobs_waiting != 0)
        begin
            engine_on = 1'b1;
            engine_tag = job_tag[0];
            o.started = 1'b1;
            o.tag = job_tag[0];
            o.prio = job_prio[0];
            for (int i = 1; i < jobs_waiting; i++)
            begin
                job_tag[i-1] = job_tag[i];
                job_prio[i-1] = job_prio[i];
            end
            jobs_waiting--;
        end
        o.count = COUNT_OUT_W'(jobs_waiting);
        return o;
    endfunction

    // Mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    // Offer one item, hold it until accepted, then record its expected result
    task automatic send_event(input logic [1:0] f, input logic [7:0] tag,
                              input logic [7:0] prio);
        sched_outcome_t o;
        int gap;
        gap = sender_gaps_on ? pick_gap() : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        func <= f;
        ctx_tag <= tag;
        req_priority <= prio;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        o = schedule_event(f, tag, prio);
        outcome_q.push_back(o);
        case (f)
            FUNC_SUBMIT: n_submit++;
            FUNC_DONE:   n_done++;
            FUNC_CANCEL: n_cancel++;
            default:     n_unused++;
        endcase
        if (o.status == STATUS_FULL)
            n_dropped++;
        if (o.status == STATUS_IDLE_DONE)
            n_idle_done++;
        if (o.started)
            n_started++;
        if (jobs_waiting > deepest)
            deepest = jobs_waiting;
    endtask

    // Drive out_ready: random stalls, and long hold-offs on request
    initial
    begin
        int stall_left;
        stall_left = 0;
        forever
        begin
            @(posedge clk);
            if (hold_request > 0)
            begin
                stall_left = hold_request;
                hold_request = 0;
            end
            if (stall_left > 0)
            begin
                out_ready <= 1'b0;
                stall_left--;
            end
            else if (receiver_stalls_on && $urandom_range(0, 3) == 0)
            begin
                stall_left = pick_gap();
                out_ready <= 1'b0;
            end
            else
                out_ready <= 1'b1;
        end
    end

    // Compare each accepted result with the oldest expectation
    initial
    begin
        sched_outcome_t want;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && out_ready)
            begin
                results_seen++;
                if (outcome_q.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: unexpected result started=%0b tag=%02h prio=%0d count=%0d status=%0d",
                                 $realtime, started, started_tag, started_priority,
                                 queue_count, status);
                end
                else
                begin
                    want = outcome_q.pop_front();
                    if (want.started !== started || want.tag !== started_tag ||
                        want.prio !== started_priority || want.count !== queue_count ||
                        want.status !== status)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                        begin
                            $display("%0t: result %0d mismatch", $realtime, results_seen);
                            $display("  expected started=%0b tag=%02h prio=%0d count=%0d status=%0d",
                                     want.started, want.tag, want.prio, want.count, want.status);
                            $display("  actual   started=%0b tag=%02h prio=%0d count=%0d status=%0d",
                                     started, started_tag, started_priority, queue_count, status);
                        end
                    end
                end
            end
        end
    end

    // Extremes of each field, each event kind and the scheduling corner cases
    task automatic test_directed();
        send_event(FUNC_DONE, 8'h00, 8'h00);     // done with an idle engine
        send_event(FUNC_UNUSED, 8'hFF, 8'hFF);   // unused kind while idle
        send_event(FUNC_SUBMIT, 8'hFF, 8'hFF);   // empty queue, clamped, starts at once
        send_event(FUNC_SUBMIT, 8'h00, 8'h00);   // default priority to the tail
        send_event(FUNC_SUBMIT, 8'h5A, 8'h03);   // jumps ahead, tail entry ages
        send_event(FUNC_SUBMIT, 8'hA5, 8'h80);   // clamped, goes to the head
        send_event(FUNC_SUBMIT, 8'h11, 8'h01);   // no lower entry, goes to the tail
        send_event(FUNC_CANCEL, 8'h5A, 8'h00);   // cancel a waiting job
        send_event(FUNC_CANCEL, 8'hFF, 8'h00);   // cancel the running job, next starts
        send_event(FUNC_DONE, 8'h00, 8'h00);     // normal completion
        send_event(FUNC_UNUSED, 8'h3C, 8'h55);   // unused kind while busy
        send_event(FUNC_CANCEL, 8'hEE, 8'h00);   // tag that is nowhere
    endtask

    // Fill the queue, overflow it, then cancel a tag held many times
    task automatic test_queue_full();
        while (jobs_waiting < QUEUE_DEPTH_DEF)
            send_event(FUNC_SUBMIT, (jobs_waiting % 2) ? 8'h33 : 8'($urandom_range(0, 255)),
                       8'($urandom_range(0, 7)));
        send_event(FUNC_SUBMIT, 8'h44, 8'h06);
        send_event(FUNC_SUBMIT, 8'h45, 8'h00);
        send_event(FUNC_CANCEL, 8'h33, 8'h00);
        send_event(FUNC_CANCEL, engine_tag, 8'h00);
    endtask

    // Hold results back for a long stretch while events keep coming
    task automatic test_backpressure();
        int r;
        sender_gaps_on = 1'b0;
        receiver_stalls_on = 1'b0;
        hold_request = 150;
        repeat (24)
        begin
            r = $urandom_range(0, 3);
            if (r < 2)
                send_event(FUNC_SUBMIT, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 7)));
            else if (r == 2)
                send_event(FUNC_DONE, 8'h00, 8'h00);
            else
                send_event(FUNC_CANCEL, engine_tag, 8'h00);
        end
        sender_gaps_on = 1'b1;
        receiver_stalls_on = 1'b1;
    endtask

    // Bursts that fill, drain or churn the queue, tags mostly from a small pool
    task automatic test_random();
        logic [7:0] pool [8];
        logic [1:0] f;
        logic [7:0] tag;
        logic [7:0] prio;
        int counted;
        int mode;
        int r;
        int sub_lim;
        int done_lim;
        int can_lim;
        foreach (pool[i])
            pool[i] = 8'($urandom_range(0, 255));
        counted = 0;
        while (counted < 700)
        begin
            mode = $urandom_range(0, 2);
            sub_lim = (mode == 0) ? 65 : (mode == 1) ? 30 : 45;
            done_lim = (mode == 0) ? 82 : 75;
            can_lim = (mode == 0) ? 95 : 93;
            sender_gaps_on = ($urandom_range(0, 3) != 0);
            receiver_stalls_on = ($urandom_range(0, 3) != 0);
            repeat ($urandom_range(10, 40))
            begin
                r = $urandom_range(0, 99);
                if (r < sub_lim)
                    f = FUNC_SUBMIT;
                else if (r < done_lim)
                    f = FUNC_DONE;
                else if (r < can_lim)
                    f = FUNC_CANCEL;
                else
                    f = FUNC_UNUSED;
                if ($urandom_range(0, 4) == 0)
                    tag = 8'($urandom_range(0, 255));
                else
                    tag = pool[$urandom_range(0, 7)];
                // aim most cancels at a job that exists
                if (f == FUNC_CANCEL && $urandom_range(0, 9) < 7)
                begin
                    if (jobs_waiting > 0 && $urandom_range(0, 1) == 1)
                        tag = job_tag[$urandom_range(0, jobs_waiting - 1)];
                    else if (engine_on)
                        tag = engine_tag;
                end
                r = $urandom_range(0, 99);
                if (r < 20)
                    prio = 8'h00;
                else if (r < 80)
                    prio = 8'($urandom_range(1, 7));
                else
                    prio = 8'($urandom_range(0, 255));
                send_event(f, tag, prio);
                if (f != FUNC_UNUSED)
                    counted++;
            end
        end
        sender_gaps_on = 1'b1;
        receiver_stalls_on = 1'b1;
    endtask

    // Run limit
    initial
    begin
        #10_000_000;
        $display("Timeout with %0d results still outstanding", outcome_q.size());
        $display("TEST FAILED");
        $finish;
    end

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        test_directed();
        test_queue_full();
        test_backpressure();
        test_random();
        in_valid <= 1'b0;
        while (outcome_q.size() != 0)
            @(posedge clk);
        repeat (25) @(posedge clk);
        $display("Ran %0d submits (%0d dropped full), %0d done (%0d while idle), %0d cancels, %0d unused",
                 n_submit, n_dropped, n_done, n_idle_done, n_cancel, n_unused);
        $display("Checked %0d results, %0d job starts, deepest queue %0d, %0d mismatches",
                 results_seen, n_started, deepest, mismatches);
        if (mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/core/apjq_pkg.sv
rtl/core/apjq_ram.sv
rtl/core/apjq_unit.sv
rtl/core/aging_priority_job_queue.sv
test/tb.sv
